>>> hw/rtl/ppmfd_pkg.sv
`timescale 1ns / 1ps

package ppmfd_pkg;

	localparam int TIME_W   = 32;
	localparam int SPAN_W   = 16;
	localparam int CHAN_W   = 12;
	localparam int OUT_CHANS = 6;
	localparam int CFG_W    = 16;
	localparam int CFG_AW   = 2;

	typedef enum logic [CFG_AW-1:0] {
		CFG_SYNC_THRESHOLD = 2'd0,
		CFG_PULSE_MIN      = 2'd1,
		CFG_PULSE_MAX      = 2'd2
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] SYNC_THRESHOLD_RST = 16'd5000;
	localparam logic [CFG_W-1:0] PULSE_MIN_RST      = 16'd950;
	localparam logic [CFG_W-1:0] PULSE_MAX_RST      = 16'd2050;

	typedef logic [CHAN_W-1:0] chan_t;

endpackage

>>> hw/rtl/ppm_frame_decoder_unit.sv
`timescale 1ns / 1ps
// ppm frame decoder: decodes an rc ppm pulse train from edge timestamps
// input stream: one beat per rising edge, s_axis_tdata = microsecond timestamp
// output stream: one beat per input beat with the six stored channel widths
// in tdata (chan_0 lowest) and the sync_seen / slot_written flags in tuser
// config port: cfg_we/cfg_addr/cfg_wdata, write only while the block is idle
// (0 sync threshold, 1 pulse min, 2 pulse max); other indexes are ignored
// path from input beat to output beat: input register, then result register;
// throughput one beat per clock while the receiver does not stall, set by the
// single subtract/compare/store pass between the two registers
// the input register keeps taking beats while a result waits, so one extra
// beat is absorbed when the receiver stalls; s_axis_tready drops only when
// both the input register and the result register are full
// reset: timestamp base goes to zero, all channels to zero, registers to their
// defaults, and no slot is open until the first sync gap
// channels with index NUM_CHANNELS and above read as zero on the output
module ppm_frame_decoder_unit #(
	parameter int NUM_CHANNELS = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ppmfd_pkg::CFG_AW-1:0]      cfg_addr,
	input  logic [ppmfd_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [ppmfd_pkg::TIME_W-1:0]      s_axis_tdata,  // edge_time
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// chan_0, chan_1, chan_2, chan_3, chan_4, chan_5
	output logic [ppmfd_pkg::OUT_CHANS*ppmfd_pkg::CHAN_W-1:0] m_axis_tdata,
	output logic [1:0]                        m_axis_tuser   // sync_seen, slot_written
);

	import ppmfd_pkg::*;

	localparam int SLOT_W = $clog2(NUM_CHANNELS + 1);
	localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(NUM_CHANNELS);

	logic [CFG_W-1:0]  sync_threshold_q;
	logic [CFG_W-1:0]  pulse_min_q;
	logic [CFG_W-1:0]  pulse_max_q;

	logic [TIME_W-1:0] last_edge_q;
	logic [SLOT_W-1:0] slot_q;
	chan_t             store_q [NUM_CHANNELS];
	chan_t             store_d [NUM_CHANNELS];

	logic              valid_s1;
	logic [TIME_W-1:0] edge_s1;

	logic              out_valid_q;
	chan_t             out_chan_q [OUT_CHANS];
	chan_t             out_chan_d [OUT_CHANS];
	logic              out_sync_q;
	logic              out_wrote_q;

	logic              advance;
	logic              fire;
	logic [TIME_W-1:0] span32;
	logic [SPAN_W-1:0] span16;
	chan_t             val12;
	logic              is_sync;
	logic              slot_open;
	logic              in_range;
	logic              wr;
	logic [SLOT_W-1:0] slot_d;

	assign advance       = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_threshold_q <= SYNC_THRESHOLD_RST;
			pulse_min_q      <= PULSE_MIN_RST;
			pulse_max_q      <= PULSE_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_SYNC_THRESHOLD: sync_threshold_q <= cfg_wdata;
				CFG_PULSE_MIN:      pulse_min_q      <= cfg_wdata;
				CFG_PULSE_MAX:      pulse_max_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			edge_s1 <= s_axis_tdata;
		end
	end

	// interval, classification and slot update
	always_comb begin
		span32    = edge_s1 - last_edge_q;
		span16    = (|span32[TIME_W-1:SPAN_W]) ? {SPAN_W{1'b1}} : span32[SPAN_W-1:0];
		val12     = (|span16[SPAN_W-1:CHAN_W]) ? {CHAN_W{1'b1}} : span16[CHAN_W-1:0];
		is_sync   = span16 > sync_threshold_q;
		slot_open = slot_q < SLOT_MAX;
		in_range  = (span16 > pulse_min_q) && (span16 <= pulse_max_q);
		wr        = !is_sync && slot_open && in_range;
		if (is_sync) begin
			slot_d = '0;
		end else if (slot_open) begin
			slot_d = SLOT_W'(slot_q + 1'b1);
		end else begin
			slot_d = slot_q;
		end
	end

	for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_store
		assign store_d[k] = (wr && (slot_q == SLOT_W'(k))) ? val12 : store_q[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				store_q[k] <= '0;
			end else if (fire) begin
				store_q[k] <= store_d[k];
			end
		end
	end

	for (genvar j = 0; j < OUT_CHANS; j++) begin : g_out
		if (j < NUM_CHANNELS) begin : g_live
			assign out_chan_d[j] = store_d[j];
		end else begin : g_zero
			assign out_chan_d[j] = '0;
		end
		assign m_axis_tdata[j*CHAN_W +: CHAN_W] = out_chan_q[j];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q <= '0;
			slot_q      <= SLOT_MAX;
		end else if (fire) begin
			last_edge_q <= edge_s1;
			slot_q      <= slot_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_chan_q  <= out_chan_d;
			out_sync_q  <= is_sync;
			out_wrote_q <= wr;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = {out_wrote_q, out_sync_q};

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_MAX)
		else $error("slot counter beyond channel count");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("sync beat also marked as slot write");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && m_axis_tvalid && !m_axis_tready))
		else $error("input stalled with room in the pipeline");

	a_sync_restarts_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_sync) |=> (slot_q == '0))
		else $error("slot counter not cleared after sync gap");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ppmfd_pkg::*;

	localparam int NUM_CH = 6;
	localparam logic [CFG_AW-1:0] CFG_NO_REG = 2'd3;

	typedef struct packed {
		logic [OUT_CHANS-1:0][CHAN_W-1:0] chans;
		logic sync_seen;
		logic slot_written;
	} ppm_frame_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_AW-1:0] cfg_addr;
	logic [CFG_W-1:0] cfg_wdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [TIME_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_CHANS*CHAN_W-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	// decoder mirror
	logic [CFG_W-1:0] sync_mdl;
	logic [CFG_W-1:0] pmin_mdl;
	logic [CFG_W-1:0] pmax_mdl;
	logic [TIME_W-1:0] last_stamp_mdl;
	int slot_mdl;
	logic [OUT_CHANS-1:0][CHAN_W-1:0] chan_mdl;

	ppm_frame_t frame_q[$];
	ppm_frame_t want_frame;
	int err_count;
	int chk_idx;

	logic [TIME_W-1:0] stamp_now;
	int burst_left;
	bit tx_idle_on;
	int rx_stall_pct;
	int hold_req;
	int hold_left;

	ppm_frame_decoder_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #6 clk = ~clk;

	function automatic ppm_frame_t decode_edge(input logic [TIME_W-1:0] stamp);
		logic [TIME_W-1:0] delta;
		logic [SPAN_W-1:0] span;
		ppm_frame_t res;
		delta = stamp - last_stamp_mdl;
		last_stamp_mdl = stamp;
		span = (delta > 32'h0000_FFFF) ? 16'hFFFF : delta[SPAN_W-1:0];
		res = '0;
		if (span > sync_mdl) begin
			slot_mdl = 0;
			res.sync_seen = 1'b1;
		end else if (slot_mdl < NUM_CH) begin
			if (span > pmin_mdl && span <= pmax_mdl) begin
				chan_mdl[slot_mdl] = (span > 16'd4095) ? 12'hFFF : span[CHAN_W-1:0];
				res.slot_written = 1'b1;
			end
			slot_mdl++;
		end
		res.chans = chan_mdl;
		return res;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (frame_q.size() == 0) begin
				$error("result beat with nothing expected");
				err_count++;
			end else begin
				want_frame = frame_q.pop_front();
				for (chk_idx = 0; chk_idx < OUT_CHANS; chk_idx++) begin
					if (m_axis_tdata[chk_idx*CHAN_W +: CHAN_W] !== want_frame.chans[chk_idx]) begin
						$error("chan_%0d expected %0d actual %0d", chk_idx,
							want_frame.chans[chk_idx], m_axis_tdata[chk_idx*CHAN_W +: CHAN_W]);
						err_count++;
					end
				end
				if (m_axis_tuser[0] !== want_frame.sync_seen) begin
					$error("sync_seen expected %0d actual %0d", want_frame.sync_seen,
						m_axis_tuser[0]);
					err_count++;
				end
				if (m_axis_tuser[1] !== want_frame.slot_written) begin
					$error("slot_written expected %0d actual %0d", want_frame.slot_written,
						m_axis_tuser[1]);
					err_count++;
				end
			end
		end
	end

	// receiver stall pattern and long hold-off
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
				m_axis_tready <= 1'b0;
				while (hold_left != 0) begin
					@(negedge clk);
					hold_left--;
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	initial begin
		#5_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	task automatic send_beat(input logic [TIME_W-1:0] stamp);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= stamp;
		do @(posedge clk); while (!s_axis_tready);
		frame_q.push_back(decode_edge(stamp));
		@(negedge clk);
	endtask

	task automatic offer(input logic [TIME_W-1:0] stamp);
		int gap_len;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (tx_idle_on) begin
				gap_len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 20) :
					$urandom_range(1, 4);
				s_axis_tvalid <= 1'b0;
				repeat (gap_len) @(negedge clk);
			end
		end
		burst_left--;
		stamp_now = stamp;
		send_beat(stamp);
	endtask

	task automatic advance(input int unsigned delta);
		offer(stamp_now + delta);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (frame_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			CFG_SYNC_THRESHOLD: sync_mdl = val;
			CFG_PULSE_MIN: pmin_mdl = val;
			CFG_PULSE_MAX: pmax_mdl = val;
			default: ;
		endcase
	endtask

	task automatic set_limits(input logic [CFG_W-1:0] sync_v, input logic [CFG_W-1:0] pmin_v,
		input logic [CFG_W-1:0] pmax_v);
		write_reg(CFG_SYNC_THRESHOLD, sync_v);
		write_reg(CFG_PULSE_MIN, pmin_v);
		write_reg(CFG_PULSE_MAX, pmax_v);
	endtask

	function automatic int unsigned sync_gap();
		int unsigned thr;
		int unsigned top;
		thr = sync_mdl;
		if (thr == 65535 || $urandom_range(0, 7) == 0)
			return $urandom_range(65536, 32'hF000_0000);
		if ($urandom_range(0, 3) == 0)
			return thr + 1;
		top = (thr > 61535) ? 65535 : thr + 4000;
		return $urandom_range(thr + 1, top);
	endfunction

	function automatic int unsigned pulse_gap();
		int unsigned lo;
		int unsigned hi;
		int unsigned pick;
		lo = (pmin_mdl < pmax_mdl) ? pmin_mdl : pmax_mdl;
		hi = (pmin_mdl < pmax_mdl) ? pmax_mdl : pmin_mdl;
		pick = $urandom_range(0, 9);
		case (pick)
			0: return ($urandom_range(0, 1) != 0) ? pmin_mdl : pmin_mdl + 1;
			1: return ($urandom_range(0, 1) != 0) ? pmax_mdl : pmax_mdl + 1;
			8: return $urandom_range(0, 4500);
			9: return $urandom_range(0, 70000);
			default: return $urandom_range(lo, hi + 1);
		endcase
	endfunction

	task automatic test_directed();
		stamp_now = '0;
		tx_idle_on = 1'b1;
		rx_stall_pct = 25;
		advance(1000);  // first edge, measured from time zero, no sync yet
		advance(1500);
		advance(5000);  // exactly at threshold, not a sync
		advance(5001);
		advance(951);
		advance(950);
		advance(2050);
		advance(2051);
		advance(1500);
		advance(1200);
		advance(1300);  // seventh pulse ignored
		advance(0);
		offer(32'hFFFF_FE00);
		advance(1512);  // timestamp wraps
		offer(32'hFFFF_FFFF);
		advance(1);
		advance(0);
		drain();
		set_limits(16'd65534, 16'd0, 16'd65535);
		write_reg(CFG_NO_REG, 16'd7);
		advance(70000);  // saturates to full scale, above threshold
		advance(65534);  // stored clipped to 12 bits
		advance(4096);
		advance(4095);
		advance(0);
		advance(1);
		advance(65535);
		drain();
	endtask

	task automatic test_random_frames(input logic [CFG_W-1:0] sync_v,
		input logic [CFG_W-1:0] pmin_v, input logic [CFG_W-1:0] pmax_v,
		input int n_beats, input int stall_pct, input bit idle_on);
		int sent;
		int n_pulse;
		drain();
		set_limits(sync_v, pmin_v, pmax_v);
		rx_stall_pct = stall_pct;
		tx_idle_on = idle_on;
		sent = 0;
		while (sent < n_beats) begin
			if ($urandom_range(0, 9) == 0) begin
				offer($urandom);
				sent++;
			end else begin
				advance(sync_gap());
				sent++;
				n_pulse = ($urandom_range(0, 9) < 7) ? NUM_CH : $urandom_range(1, 9);
				repeat (n_pulse) begin
					advance(pulse_gap());
					sent++;
				end
			end
		end
		drain();
	endtask

	task automatic test_back_pressure();
		drain();
		set_limits(SYNC_THRESHOLD_RST, PULSE_MIN_RST, PULSE_MAX_RST);
		rx_stall_pct = 0;
		tx_idle_on = 1'b0;
		hold_req = 60;
		repeat (3) begin
			advance(sync_gap());
			repeat (NUM_CH) advance(pulse_gap());
		end
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		err_count = 0;
		burst_left = 0;
		tx_idle_on = 1'b1;
		rx_stall_pct = 0;
		hold_req = 0;
		sync_mdl = SYNC_THRESHOLD_RST;
		pmin_mdl = PULSE_MIN_RST;
		pmax_mdl = PULSE_MAX_RST;
		last_stamp_mdl = '0;
		slot_mdl = NUM_CH;
		chan_mdl = '0;
		stamp_now = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_back_pressure();
		test_random_frames(SYNC_THRESHOLD_RST, PULSE_MIN_RST, PULSE_MAX_RST, 80, 0, 1'b1);
		test_random_frames(16'd8000, 16'd500, 16'd4500, 80, 30, 1'b1);
		test_random_frames(16'd65535, 16'd0, 16'd65535, 60, 50, 1'b0);
		test_random_frames(16'd0, 16'd0, 16'd0, 50, 20, 1'b1);
		test_random_frames(16'd3000, 16'd65535, 16'd0, 40, 10, 1'b0);
		test_random_frames(16'd2500, 16'd1000, 16'd2000, 80, 70, 1'b1);
		drain();

		if (err_count == 0 && frame_q.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/ppmfd_pkg.sv
hw/rtl/ppm_frame_decoder_unit.sv
tb/sv/testbench.sv
